FILE: src/udp_rx_pkg.sv
// Shared types and constants for the UDP receive verifier and port demultiplexer.
package udp_rx_pkg;

  // Default number of port binding slots
  localparam int unsigned BINDING_SLOTS_DEF = 16;

  // Input item modes
  typedef enum logic [1:0] {
    MODE_BIND   = 2'd0,
    MODE_UNBIND = 2'd1,
    MODE_START  = 2'd2,
    MODE_BYTE   = 2'd3
  } mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BIND    = 2'd0,
    KIND_UNBIND  = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PORT_ZERO  = 3'd1,
    ST_BOUND      = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_BOUND  = 3'd4,
    ST_MALFORMED  = 3'd5,
    ST_BAD_CSUM   = 3'd6,
    ST_NO_BINDING = 3'd7
  } status_t;

  // UDP header is eight bytes
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  // IP protocol number of UDP, sized for the pseudo-header address sum
  localparam logic [18:0] PROTO_UDP = 19'd17;

  // Binding table lookup answer
  typedef struct packed {
    logic       hit;
    logic [3:0] hit_slot;
    logic       free;
    logic [3:0] free_slot;
  } bt_lookup_t;

  // Segment check answer at the last byte
  typedef struct packed {
    logic        fire;
    logic        malformed;
    logic        csum_bad;
    logic [15:0] hdr_sport;
    logic [15:0] hdr_dport;
    logic [15:0] plen;
  } seg_verdict_t;

endpackage

FILE: src/udp_rx_verify_and_port_demux_unit.sv
// Top level of the UDP receive verifier and destination port demultiplexer.
// Accepts one item per clock unless stalled: bind, unbind, packet start or one
// segment byte. Each item is captured in an input register and handled in one pass
// through the port table compare and the checksum fold into a result register, so
// items flow at one per cycle while the result register is free or being taken.
// While the result register holds a result not yet taken, the input register holds
// its item and only an empty input register takes a new one, so the input stalls
// until the result is taken.
// The binding table clears its slot valid flags at reset.
module udp_rx_verify_and_port_demux_unit #(
  parameter int unsigned BINDING_SLOTS = udp_rx_pkg::BINDING_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] port_number,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] received_count,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [2:0]  status_code,
  output logic [3:0]  slot_index,
  output logic [15:0] src_port_out,
  output logic [15:0] dst_port_out,
  output logic [15:0] payload_length
);

  // Input register
  logic                     s1_valid;
  udp_rx_pkg::mode_t        s1_mode;
  logic [15:0]              s1_port;
  logic [31:0]              s1_src;
  logic [31:0]              s1_dst;
  logic [15:0]              s1_count;
  logic [7:0]               s1_data;

  logic                     advance;
  logic [15:0]              key;
  logic                     do_bind;
  logic                     do_unbind;
  udp_rx_pkg::bt_lookup_t   lookup;
  udp_rx_pkg::seg_verdict_t verdict;

  logic                     res_fire;
  udp_rx_pkg::kind_t        res_kind;
  udp_rx_pkg::status_t      res_status;
  logic [3:0]               res_slot;
  logic [15:0]              res_sp;
  logic [15:0]              res_dp;
  logic [15:0]              res_plen;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Capture the item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode  <= udp_rx_pkg::mode_t'(mode);
      s1_port  <= port_number;
      s1_src   <= source_address;
      s1_dst   <= dest_address;
      s1_count <= received_count;
      s1_data  <= data_byte;
    end
  end

  // Look up the bind or unbind port, or the header destination port for a segment byte
  assign key       = (s1_mode == udp_rx_pkg::MODE_BYTE) ? verdict.hdr_dport : s1_port;
  assign do_bind   = advance && (s1_mode == udp_rx_pkg::MODE_BIND) && (s1_port != 16'd0)
                     && !lookup.hit && lookup.free;
  assign do_unbind = advance && (s1_mode == udp_rx_pkg::MODE_UNBIND) && lookup.hit;

  udp_rx_bind_table #(
    .BINDING_SLOTS(BINDING_SLOTS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .do_bind   (do_bind),
    .do_unbind (do_unbind),
    .lookup    (lookup)
  );

  udp_rx_seg_check u_seg (
    .clk            (clk),
    .rst            (rst),
    .start          (advance && (s1_mode == udp_rx_pkg::MODE_START)),
    .source_address (s1_src),
    .dest_address   (s1_dst),
    .received_count (s1_count),
    .byte_en        (advance && (s1_mode == udp_rx_pkg::MODE_BYTE)),
    .data_byte      (s1_data),
    .verdict        (verdict)
  );

  // Build the result for the item in the input register
  always_comb begin
    res_fire   = 1'b0;
    res_kind   = udp_rx_pkg::KIND_BIND;
    res_status = udp_rx_pkg::ST_OK;
    res_slot   = 4'd0;
    res_sp     = 16'd0;
    res_dp     = 16'd0;
    res_plen   = 16'd0;
    case (s1_mode)
      udp_rx_pkg::MODE_BIND: begin
        res_fire = 1'b1;
        res_kind = udp_rx_pkg::KIND_BIND;
        if (s1_port == 16'd0) begin
          res_status = udp_rx_pkg::ST_PORT_ZERO;
        end else if (lookup.hit) begin
          res_status = udp_rx_pkg::ST_BOUND;
        end else if (!lookup.free) begin
          res_status = udp_rx_pkg::ST_FULL;
        end else begin
          res_slot = lookup.free_slot;
        end
      end
      udp_rx_pkg::MODE_UNBIND: begin
        res_fire = 1'b1;
        res_kind = udp_rx_pkg::KIND_UNBIND;
        if (lookup.hit) begin
          res_slot = lookup.hit_slot;
        end else begin
          res_status = udp_rx_pkg::ST_NOT_BOUND;
        end
      end
      udp_rx_pkg::MODE_START: begin
        res_kind = udp_rx_pkg::KIND_VERDICT;
        if (s1_count < udp_rx_pkg::UDP_HDR_BYTES) begin
          res_fire   = 1'b1;
          res_status = udp_rx_pkg::ST_MALFORMED;
        end
      end
      udp_rx_pkg::MODE_BYTE: begin
        res_kind = udp_rx_pkg::KIND_VERDICT;
        res_fire = verdict.fire;
        if (verdict.malformed) begin
          res_status = udp_rx_pkg::ST_MALFORMED;
        end else begin
          res_sp   = verdict.hdr_sport;
          res_dp   = verdict.hdr_dport;
          res_plen = verdict.plen;
          if (verdict.csum_bad) begin
            res_status = udp_rx_pkg::ST_BAD_CSUM;
          end else if (lookup.hit) begin
            res_slot = lookup.hit_slot;
          end else begin
            res_status = udp_rx_pkg::ST_NO_BINDING;
          end
        end
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      result_kind    <= res_kind;
      status_code    <= res_status;
      slot_index     <= res_slot;
      src_port_out   <= res_sp;
      dst_port_out   <= res_dp;
      payload_length <= res_plen;
    end
  end

endmodule

FILE: src/udp_rx_bind_table.sv
// Port binding table: parallel compare, lowest free slot search, bind and unbind writes.
module udp_rx_bind_table #(
  parameter int unsigned BINDING_SLOTS = udp_rx_pkg::BINDING_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [15:0]            key,
  input  logic                   do_bind,
  input  logic                   do_unbind,
  output udp_rx_pkg::bt_lookup_t lookup
);

  localparam int unsigned SLOT_W = (BINDING_SLOTS > 1) ? $clog2(BINDING_SLOTS) : 1;

  logic [15:0]        bound_ports [BINDING_SLOTS];
  logic [BINDING_SLOTS-1:0] slot_valid;
  logic               hit;
  logic               free;
  logic [SLOT_W-1:0]  hit_idx;
  logic [SLOT_W-1:0]  free_idx;

  // Compare all slots; scan downward so the lowest slot wins
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = BINDING_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && (bound_ports[i] == key)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        free     = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign lookup.hit       = hit;
  assign lookup.hit_slot  = 4'(hit_idx);
  assign lookup.free      = free;
  assign lookup.free_slot = 4'(free_idx);

  // Write the port into the lowest free slot on bind
  always_ff @(posedge clk) begin
    if (do_bind) begin
      bound_ports[free_idx] <= key;
    end
  end

  // Set valid on bind, drop it on unbind
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (do_bind) begin
      slot_valid[free_idx] <= 1'b1;
    end else if (do_unbind) begin
      slot_valid[hit_idx] <= 1'b0;
    end
  end

endmodule

FILE: src/udp_rx_seg_check.sv
// Segment tracker: header capture, one's complement sum and verdict at the last byte.
module udp_rx_seg_check (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [31:0]              source_address,
  input  logic [31:0]              dest_address,
  input  logic [15:0]              received_count,
  input  logic                     byte_en,
  input  logic [7:0]               data_byte,
  output udp_rx_pkg::seg_verdict_t verdict
);

  logic        in_packet;
  logic [18:0] addr_sum;
  logic [15:0] bytes_expected;
  logic [15:0] byte_counter;
  logic [31:0] sum_accumulator;
  logic [7:0]  pending_high_byte;
  logic [63:0] header_fields;

  logic        take;
  logic        hdr_phase;
  logic        summed;
  logic [15:0] len_r;
  logic [15:0] seg_r;
  logic [63:0] header_next;
  logic [7:0]  pending_next;
  logic [31:0] sum_next;
  logic [15:0] counter_next;
  logic        last;
  logic [15:0] len_n;
  logic [15:0] seg_n;
  logic [15:0] pad;
  logic [32:0] total;
  logic [17:0] fold1;
  logic [16:0] fold2;
  logic [15:0] fold3;

  assign take = byte_en && in_packet;

  // Track header bytes and summed span of the segment
  always_comb begin
    len_r        = header_fields[31:16];
    seg_r        = (len_r > bytes_expected) ? bytes_expected : len_r;
    hdr_phase    = byte_counter < udp_rx_pkg::UDP_HDR_BYTES;
    summed       = hdr_phase || (byte_counter < seg_r);
    header_next  = hdr_phase ? {header_fields[55:0], data_byte} : header_fields;
    pending_next = (summed && !byte_counter[0]) ? data_byte : pending_high_byte;
    sum_next     = (summed && byte_counter[0])
                   ? sum_accumulator + {16'd0, pending_high_byte, data_byte}
                   : sum_accumulator;
    counter_next = byte_counter + 16'd1;
    last         = counter_next == bytes_expected;
  end

  // Close the sum with pad byte and pseudo-header, then fold
  always_comb begin
    len_n = header_next[31:16];
    seg_n = (len_n > bytes_expected) ? bytes_expected : len_n;
    pad   = seg_n[0] ? {pending_next, 8'h00} : 16'd0;
    total = {1'b0, sum_next} + {17'd0, pad} + {14'd0, addr_sum} + {17'd0, len_n};
    fold1 = {2'b00, total[15:0]} + {1'b0, total[32:16]};
    fold2 = {1'b0, fold1[15:0]} + {15'd0, fold1[17:16]};
    fold3 = fold2[15:0] + {15'd0, fold2[16]};
  end

  assign verdict.fire      = take && last;
  assign verdict.malformed = len_n < udp_rx_pkg::UDP_HDR_BYTES;
  assign verdict.csum_bad  = (header_next[15:0] != 16'd0) && (fold3 != 16'hFFFF);
  assign verdict.hdr_sport = header_next[63:48];
  assign verdict.hdr_dport = header_next[47:32];
  assign verdict.plen      = seg_n - udp_rx_pkg::UDP_HDR_BYTES;

  // Open a segment on start, advance on each byte
  always_ff @(posedge clk) begin
    if (start) begin
      addr_sum          <= {3'b000, source_address[31:16]} + {3'b000, source_address[15:0]}
                           + {3'b000, dest_address[31:16]} + {3'b000, dest_address[15:0]}
                           + udp_rx_pkg::PROTO_UDP;
      bytes_expected    <= received_count;
      byte_counter      <= 16'd0;
      sum_accumulator   <= 32'd0;
      pending_high_byte <= 8'd0;
      header_fields     <= 64'd0;
    end else if (take) begin
      byte_counter      <= counter_next;
      sum_accumulator   <= sum_next;
      pending_high_byte <= pending_next;
      header_fields     <= header_next;
    end
  end

  // Packet open flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet <= 1'b0;
    end else if (start) begin
      in_packet <= received_count >= udp_rx_pkg::UDP_HDR_BYTES;
    end else if (take && last) begin
      in_packet <= 1'b0;
    end
  end

endmodule

FILE: test/udp_rx_verify_and_port_demux_unit_tb.sv
// Self-checking bench for the UDP receive verifier: random bind, unbind and segment traffic.
module testbench;

  localparam int SLOTS        = udp_rx_pkg::BINDING_SLOTS_DEF;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 12;
  localparam int ITEM_GOAL    = 1100;
  localparam int POOL_SIZE    = 24;
  localparam int MAX_REPORTS  = 100;

  // Checksum field choices for generated segments
  localparam int CS_GOOD = 0;
  localparam int CS_NONE = 1;
  localparam int CS_BAD  = 2;

  typedef struct packed {
    udp_rx_pkg::mode_t mode;
    logic [15:0]       port;
    logic [31:0]       src_ip;
    logic [31:0]       dst_ip;
    logic [15:0]       count;
    logic [7:0]        data;
  } item_t;

  typedef struct packed {
    udp_rx_pkg::kind_t   kind;
    udp_rx_pkg::status_t status;
    logic [3:0]          slot;
    logic [15:0]         sport;
    logic [15:0]         dport;
    logic [15:0]         plen;
  } answer_t;

  // Tracks the binding table and the open segment, predicts every answer
  class udp_demux_scoreboard;
    logic [15:0] port_of [SLOTS];
    bit          taken [SLOTS];
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] rx_count;
    logic [15:0] byte_idx;
    logic [31:0] word_sum;
    logic [7:0]  high_byte;
    logic [63:0] header;
    bit          open_seg;
    answer_t     awaited_answers [$];
    int          counted_items;
    int          results_seen;
    int          verdicts_seen;
    int          errors;
    int          status_hits [8];

    function new();
      int i;
      for (i = 0; i < SLOTS; i++) begin
        port_of[i] = '0;
        taken[i]   = 1'b0;
      end
      src_ip = '0;
      dst_ip = '0;
      rx_count = '0;
      byte_idx = '0;
      word_sum = '0;
      high_byte = '0;
      header = '0;
      open_seg = 1'b0;
    endfunction

    function void push_answer(udp_rx_pkg::kind_t k, udp_rx_pkg::status_t st,
                              logic [3:0] slot, logic [15:0] sp, logic [15:0] dp,
                              logic [15:0] plen);
      answer_t a;
      a.kind = k;
      a.status = st;
      a.slot = slot;
      a.sport = sp;
      a.dport = dp;
      a.plen = plen;
      awaited_answers.push_back(a);
    endfunction

    // Length field clamped to the bytes actually received
    function logic [15:0] clamped_len();
      logic [15:0] len_f;
      len_f = header[31:16];
      return (len_f > rx_count) ? rx_count : len_f;
    endfunction

    // Verdict after the last received byte
    function void close_segment();
      logic [15:0] len_f;
      logic [15:0] csum_f;
      logic [15:0] sp;
      logic [15:0] dp;
      logic [15:0] seg;
      logic [63:0] s;
      int          i;
      len_f  = header[31:16];
      csum_f = header[15:0];
      sp     = header[63:48];
      dp     = header[47:32];
      if (len_f < udp_rx_pkg::UDP_HDR_BYTES) begin
        push_answer(udp_rx_pkg::KIND_VERDICT, udp_rx_pkg::ST_MALFORMED, 4'd0,
                    16'd0, 16'd0, 16'd0);
        return;
      end
      seg = clamped_len();
      s = word_sum;
      if (seg[0]) s += {high_byte, 8'h00};
      s += src_ip[31:16];
      s += src_ip[15:0];
      s += dst_ip[31:16];
      s += dst_ip[15:0];
      s += udp_rx_pkg::PROTO_UDP;
      s += len_f;
      while (s[63:16] != 0) s = s[15:0] + s[63:16];
      if (csum_f != 16'd0 && s[15:0] != 16'hFFFF) begin
        push_answer(udp_rx_pkg::KIND_VERDICT, udp_rx_pkg::ST_BAD_CSUM, 4'd0,
                    sp, dp, seg - 16'd8);
        return;
      end
      for (i = 0; i < SLOTS; i++) begin
        if (taken[i] && port_of[i] == dp) begin
          push_answer(udp_rx_pkg::KIND_VERDICT, udp_rx_pkg::ST_OK, 4'(i),
                      sp, dp, seg - 16'd8);
          return;
        end
      end
      push_answer(udp_rx_pkg::KIND_VERDICT, udp_rx_pkg::ST_NO_BINDING, 4'd0,
                  sp, dp, seg - 16'd8);
    endfunction

    // Apply one accepted item and queue the answer it causes
    function void note_item(item_t it);
      int          i;
      int          free_slot;
      bit          hit;
      bit          summed;
      logic [15:0] idx;
      free_slot = -1;
      hit = 1'b0;
      case (it.mode)
        udp_rx_pkg::MODE_BIND: begin
          counted_items++;
          if (it.port == 16'd0) begin
            push_answer(udp_rx_pkg::KIND_BIND, udp_rx_pkg::ST_PORT_ZERO, 4'd0,
                        16'd0, 16'd0, 16'd0);
          end else begin
            for (i = 0; i < SLOTS; i++) begin
              if (taken[i] && port_of[i] == it.port) hit = 1'b1;
              if (!taken[i] && free_slot < 0) free_slot = i;
            end
            if (hit) begin
              push_answer(udp_rx_pkg::KIND_BIND, udp_rx_pkg::ST_BOUND, 4'd0,
                          16'd0, 16'd0, 16'd0);
            end else if (free_slot < 0) begin
              push_answer(udp_rx_pkg::KIND_BIND, udp_rx_pkg::ST_FULL, 4'd0,
                          16'd0, 16'd0, 16'd0);
            end else begin
              port_of[free_slot] = it.port;
              taken[free_slot] = 1'b1;
              push_answer(udp_rx_pkg::KIND_BIND, udp_rx_pkg::ST_OK, 4'(free_slot),
                          16'd0, 16'd0, 16'd0);
            end
          end
        end
        udp_rx_pkg::MODE_UNBIND: begin
          counted_items++;
          for (i = 0; i < SLOTS; i++) begin
            if (!hit && taken[i] && port_of[i] == it.port) begin
              hit = 1'b1;
              taken[i] = 1'b0;
              push_answer(udp_rx_pkg::KIND_UNBIND, udp_rx_pkg::ST_OK, 4'(i),
                          16'd0, 16'd0, 16'd0);
            end
          end
          if (!hit) push_answer(udp_rx_pkg::KIND_UNBIND, udp_rx_pkg::ST_NOT_BOUND, 4'd0,
                                16'd0, 16'd0, 16'd0);
        end
        udp_rx_pkg::MODE_START: begin
          counted_items++;
          src_ip = it.src_ip;
          dst_ip = it.dst_ip;
          rx_count = it.count;
          byte_idx = '0;
          word_sum = '0;
          high_byte = '0;
          header = '0;
          if (it.count < udp_rx_pkg::UDP_HDR_BYTES) begin
            open_seg = 1'b0;
            push_answer(udp_rx_pkg::KIND_VERDICT, udp_rx_pkg::ST_MALFORMED, 4'd0,
                        16'd0, 16'd0, 16'd0);
          end else begin
            open_seg = 1'b1;
          end
        end
        default: begin
          // Drop bytes that arrive with no segment open
          if (open_seg) begin
            counted_items++;
            idx = byte_idx;
            if (idx < udp_rx_pkg::UDP_HDR_BYTES) begin
              header = {header[55:0], it.data};
              summed = 1'b1;
            end else begin
              summed = idx < clamped_len();
            end
            if (summed) begin
              if (!idx[0]) high_byte = it.data;
              else word_sum += {16'd0, high_byte, it.data};
            end
            byte_idx = byte_idx + 16'd1;
            if (byte_idx == rx_count) begin
              open_seg = 1'b0;
              close_segment();
            end
          end
        end
      endcase
    endfunction

    function void compare_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    // Compare one delivered answer with the oldest one awaited
    function void check_answer(answer_t got);
      answer_t want;
      results_seen++;
      if (awaited_answers.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual kind %0d status %0d slot %0d",
                   $time, got.kind, got.status, got.slot);
        return;
      end
      want = awaited_answers.pop_front();
      compare_field("result_kind", 16'(want.kind), 16'(got.kind));
      compare_field("status_code", 16'(want.status), 16'(got.status));
      compare_field("slot_index", 16'(want.slot), 16'(got.slot));
      compare_field("src_port_out", want.sport, got.sport);
      compare_field("dst_port_out", want.dport, got.dport);
      compare_field("payload_length", want.plen, got.plen);
      if (want.kind == udp_rx_pkg::KIND_VERDICT) verdicts_seen++;
      status_hits[want.status]++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [15:0] port_number;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] received_count;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  result_kind;
  logic [2:0]  status_code;
  logic [3:0]  slot_index;
  logic [15:0] src_port_out;
  logic [15:0] dst_port_out;
  logic [15:0] payload_length;

  udp_demux_scoreboard sb;
  item_t       seen_item;
  answer_t     seen_answer;
  logic [7:0]  seg_bytes [$];
  logic [15:0] port_pool [POOL_SIZE];
  bit          sender_quiet;
  bit          rx_calm;
  bit          hold_request;
  int          stall_left;
  int          cycle_count;

  udp_rx_verify_and_port_demux_unit #(
    .BINDING_SLOTS(SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .port_number(port_number),
    .source_address(source_address),
    .dest_address(dest_address),
    .received_count(received_count),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .status_code(status_code),
    .slot_index(slot_index),
    .src_port_out(src_port_out),
    .dst_port_out(dst_port_out),
    .payload_length(payload_length)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen_item.mode   = udp_rx_pkg::mode_t'(mode);
        seen_item.port   = port_number;
        seen_item.src_ip = source_address;
        seen_item.dst_ip = dest_address;
        seen_item.count  = received_count;
        seen_item.data   = data_byte;
        sb.note_item(seen_item);
      end
      if (out_valid && out_ready) begin
        seen_answer.kind   = udp_rx_pkg::kind_t'(result_kind);
        seen_answer.status = udp_rx_pkg::status_t'(status_code);
        seen_answer.slot   = slot_index;
        seen_answer.sport  = src_port_out;
        seen_answer.dport  = dst_port_out;
        seen_answer.plen   = payload_length;
        sb.check_answer(seen_answer);
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready <= 1'b1;
        hold_request = 1'b0;
      end else begin
        if (stall_left == 0 && !rx_calm && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 14);
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    if (sender_quiet) return 0;
    if ($urandom_range(0, 5) == 0) return $urandom_range(1, 14);
    return 0;
  endfunction

  function automatic logic [15:0] pick_port();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return port_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Offer one item at the falling edge and hold it until accepted
  task automatic send_item(input udp_rx_pkg::mode_t m, input logic [15:0] port,
                           input logic [31:0] sa, input logic [31:0] da,
                           input logic [15:0] cnt, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= m;
    port_number    <= port;
    source_address <= sa;
    dest_address   <= da;
    received_count <= cnt;
    data_byte      <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_bind(input logic [15:0] port);
    send_item(udp_rx_pkg::MODE_BIND, port, $urandom, $urandom, 16'($urandom),
              8'($urandom));
  endtask

  task automatic send_unbind(input logic [15:0] port);
    send_item(udp_rx_pkg::MODE_UNBIND, port, $urandom, $urandom, 16'($urandom),
              8'($urandom));
  endtask

  task automatic send_start(input logic [31:0] sa, input logic [31:0] da,
                            input logic [15:0] cnt);
    send_item(udp_rx_pkg::MODE_START, 16'($urandom), sa, da, cnt, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(udp_rx_pkg::MODE_BYTE, 16'($urandom), $urandom, $urandom, 16'($urandom), b);
  endtask

  // Stop offering and wait until every awaited answer has arrived
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.awaited_answers.size() != 0);
  endtask

  // Build a segment with the chosen checksum and send its first cut bytes
  task automatic send_packet(input logic [31:0] sa, input logic [31:0] da,
                             input logic [15:0] cnt, input logic [15:0] sp,
                             input logic [15:0] dp, input logic [15:0] len,
                             input int csum_kind, input int cut,
                             input bit mid_bind, input logic [15:0] mid_port);
    logic [31:0] acc;
    logic [15:0] good_csum;
    logic [15:0] word;
    int          seg;
    int          i;
    seg_bytes = {};
    seg_bytes.push_back(sp[15:8]);
    seg_bytes.push_back(sp[7:0]);
    seg_bytes.push_back(dp[15:8]);
    seg_bytes.push_back(dp[7:0]);
    seg_bytes.push_back(len[15:8]);
    seg_bytes.push_back(len[7:0]);
    seg_bytes.push_back(8'h00);
    seg_bytes.push_back(8'h00);
    for (i = 8; i < cnt; i++) seg_bytes.push_back(8'($urandom));
    // One's complement sum over pseudo-header and clamped segment
    seg = (len > cnt) ? cnt : len;
    acc = sa[31:16] + sa[15:0] + da[31:16] + da[15:0] + 32'd17 + len;
    for (i = 0; i < seg; i += 2)
      acc += {seg_bytes[i], ((i + 1 < seg) ? seg_bytes[i + 1] : 8'h00)};
    while (acc[31:16] != 0) acc = acc[15:0] + acc[31:16];
    good_csum = ~acc[15:0];
    if (csum_kind == CS_GOOD) word = good_csum;
    else if (csum_kind == CS_BAD) word = good_csum ^ 16'h0100;
    else word = 16'd0;
    seg_bytes[6] = word[15:8];
    seg_bytes[7] = word[7:0];
    send_start(sa, da, cnt);
    for (i = 0; i < cut; i++) begin
      if (mid_bind && i == 3) send_bind(mid_port);
      else if ($urandom_range(0, 39) == 0) begin
        if ($urandom_range(0, 1) == 0) send_bind(pick_port());
        else send_unbind(pick_port());
      end
      send_byte(seg_bytes[i]);
    end
  endtask

  task automatic send_random_packet();
    logic [15:0] cnt;
    logic [15:0] len;
    int          r;
    int          cut;
    int          kind_pick;
    cnt = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(100, 300))
                                        : 16'($urandom_range(8, 40));
    r = $urandom_range(0, 9);
    if (r <= 5) len = cnt;
    else if (r == 6) len = 16'($urandom_range(8, cnt));
    else if (r == 7) len = 16'($urandom_range(cnt + 1, 65535));
    else if (r == 8) len = 16'($urandom_range(0, 7));
    else len = 16'($urandom);
    cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, cnt - 1) : cnt;
    r = $urandom_range(0, 9);
    kind_pick = (r < 6) ? CS_GOOD : (r < 8) ? CS_NONE : CS_BAD;
    send_packet($urandom, $urandom, cnt, 16'($urandom), pick_port(), len, kind_pick, cut,
                1'b0, 16'd0);
  endtask

  // Stray bytes, short starts and starts that get abandoned
  task automatic send_noise();
    int r;
    int n;
    r = $urandom_range(0, 2);
    if (r == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'($urandom));
    end else if (r == 1) begin
      send_start($urandom, $urandom, 16'($urandom_range(0, 7)));
    end else begin
      send_start($urandom, $urandom, 16'($urandom));
      n = $urandom_range(0, 5);
      repeat (n) send_byte(8'($urandom));
    end
  endtask

  task automatic run_mix(input int goal, input int min_verdicts, input int bind_w,
                         input int unbind_w);
    int r;
    while (sb.counted_items < goal || sb.verdicts_seen < min_verdicts) begin
      r = $urandom_range(0, 99);
      if (r < bind_w) send_bind(pick_port());
      else if (r < bind_w + unbind_w) send_unbind(pick_port());
      else if (r < 90) send_random_packet();
      else send_noise();
    end
  endtask

  // Keep offering answer-producing items while the result side holds off
  task automatic fill_while_held();
    int i;
    int r;
    sender_quiet = 1'b1;
    hold_request = 1'b1;
    for (i = 0; i < 40; i++) begin
      r = $urandom_range(0, 2);
      if (r == 0) send_bind(pick_port());
      else if (r == 1) send_unbind(pick_port());
      else send_start($urandom, $urandom, 16'($urandom_range(0, 7)));
    end
    wait_results_drained();
    sender_quiet = 1'b0;
  endtask

  // Main sequence
  initial begin
    int i;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    mode = udp_rx_pkg::MODE_BIND;
    port_number = '0;
    source_address = '0;
    dest_address = '0;
    received_count = '0;
    data_byte = '0;
    sender_quiet = 1'b0;
    rx_calm = 1'b0;
    hold_request = 1'b0;
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    port_pool[2] = 16'h8000;
    port_pool[3] = 16'h0001;
    for (i = 4; i < POOL_SIZE; i++) port_pool[i] = 16'($urandom_range(2, 65534));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Table corner cases
    send_bind(16'h0000);
    send_unbind(16'h0000);
    send_bind(16'hFFFF);
    send_bind(16'hFFFF);
    send_bind(16'h0001);
    send_unbind(16'h1234);
    // Stray byte with nothing open, then short starts
    send_byte(8'hA5);
    send_start(32'h0000_0000, 32'h0000_0000, 16'd0);
    send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd7);
    // Header-only, odd length, bad checksum, no checksum to an unbound port
    send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd8, 16'h0000, 16'hFFFF, 16'd8, CS_GOOD, 8,
                1'b0, 16'd0);
    send_packet(32'h0000_0000, 32'h0000_0000, 16'd9, 16'hFFFF, 16'h0001, 16'd9, CS_GOOD, 9,
                1'b0, 16'd0);
    send_packet($urandom, $urandom, 16'd10, 16'h0005, 16'hFFFF, 16'd10, CS_BAD, 10,
                1'b0, 16'd0);
    send_packet($urandom, $urandom, 16'd12, 16'h00FF, 16'h4321, 16'd12, CS_NONE, 12,
                1'b0, 16'd0);
    // Length field below the header, above the count, and below the count
    send_packet($urandom, $urandom, 16'd12, 16'h0007, 16'hFFFF, 16'd3, CS_GOOD, 12,
                1'b0, 16'd0);
    send_packet($urandom, $urandom, 16'd12, 16'h0007, 16'h0001, 16'd20, CS_GOOD, 12,
                1'b0, 16'd0);
    send_packet($urandom, $urandom, 16'd14, 16'h0007, 16'h0001, 16'd10, CS_GOOD, 14,
                1'b0, 16'd0);
    // Abandon a huge segment, then bind the port of the next one mid-segment
    send_start($urandom, $urandom, 16'hFFFF);
    repeat (3) send_byte(8'($urandom));
    send_packet($urandom, $urandom, 16'd16, 16'h1111, 16'h2222, 16'd16, CS_GOOD, 16,
                1'b1, 16'h2222);
    // Freed slot is reused lowest first
    send_unbind(16'hFFFF);
    send_bind(16'h0007);
    wait_results_drained();

    // Random traffic: bind heavy, held off, unbind heavy, balanced, then calm
    run_mix(350, 0, 45, 10);
    fill_while_held();
    run_mix(650, 0, 10, 40);
    wait_results_drained();
    run_mix(950, 0, 25, 25);
    sender_quiet = 1'b1;
    rx_calm = 1'b1;
    run_mix(ITEM_GOAL, 40, 25, 25);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.awaited_answers.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.awaited_answers.size());
    end
    $display("Run covered %0d items and %0d results, %0d of them packet verdicts",
             sb.counted_items, sb.results_seen, sb.verdicts_seen);
    $display("Statuses: ok %0d, port zero %0d, bound %0d, full %0d, not bound %0d,",
             sb.status_hits[udp_rx_pkg::ST_OK], sb.status_hits[udp_rx_pkg::ST_PORT_ZERO],
             sb.status_hits[udp_rx_pkg::ST_BOUND], sb.status_hits[udp_rx_pkg::ST_FULL],
             sb.status_hits[udp_rx_pkg::ST_NOT_BOUND]);
    $display("  malformed %0d, bad checksum %0d, no binding %0d",
             sb.status_hits[udp_rx_pkg::ST_MALFORMED], sb.status_hits[udp_rx_pkg::ST_BAD_CSUM],
             sb.status_hits[udp_rx_pkg::ST_NO_BINDING]);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/udp_rx_pkg.sv
src/udp_rx_bind_table.sv
src/udp_rx_seg_check.sv
src/udp_rx_verify_and_port_demux_unit.sv
test/udp_rx_verify_and_port_demux_unit_tb.sv
